@@ sv/prf_pkg.sv @@
// ----------------------------------------------------------------------------
// Pollard rho factor finder package
// Payload types and status codes shared by the factor finder.
// ----------------------------------------------------------------------------
package prf_pkg;

    localparam int FIELD_BITS = 32;
    localparam int LIMIT_BITS = 24;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 24'd1048576;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_LIMIT   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic [FIELD_BITS-1:0] modulus_n;
        logic [FIELD_BITS-1:0] start_summand;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_BITS-1:0] factor;
        logic [FIELD_BITS-1:0] summand_used;
        t_status               status;
    } t_out_item;

endpackage

@@ sv/pollard_rho_factor_finder.sv @@
// ----------------------------------------------------------------------------
// Pollard rho factor finder
// Finds a nontrivial factor of n by Pollard rho with Floyd cycle detection.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. Busy is high from the edge that takes
// start until the edge that raises the result strobe. The summand is first
// reduced modulo n one bit per cycle, at the start of a transaction and after
// every restart. Each round has a check state and three modular squarings.
// Each squaring has a setup step, a shift-and-add step per significant bit of
// the operand plus an exit step, and a final add of the summand. The round
// then runs a binary GCD of |tortoise - hare| and n. The number of rounds is
// bounded by the step limit. A modulus below two is answered in the check
// state after the summand reduction. The result is shown for one cycle on
// o_result_valid and cannot be stalled by the receiver.
module pollard_rho_factor_finder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  prf_pkg::t_in_item i_item,
    output logic              o_result_valid,
    output prf_pkg::t_out_item o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [prf_pkg::LIMIT_BITS-1:0] i_cfg_data
);
    import prf_pkg::*;

    localparam int W  = FIELD_BITS;
    localparam int CW = $clog2(W);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CRED    = 10'b0000000010,
        S_CHECK   = 10'b0000000100,
        S_MINIT   = 10'b0000001000,
        S_MUL     = 10'b0000010000,
        S_ADDC    = 10'b0000100000,
        S_GINIT   = 10'b0001000000,
        S_GTWO    = 10'b0010000000,
        S_GLOOP   = 10'b0100000000,
        S_RESTART = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic [LIMIT_BITS-1:0] r_limit, r_steps;
    logic [W-1:0] r_mod, r_sum, r_csh, r_cred, r_tort, r_hare;
    logic [W-1:0] r_acc, r_base, r_k;
    logic [1:0]   r_phase;
    logic [W-1:0] r_ga, r_gb;
    logic [CW-1:0] r_twos;
    logic [CW-1:0] r_cnt;
    logic        r_rvalid;
    t_out_item   r_result;

    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign o_result_valid = r_rvalid;
    assign o_result = r_result;

    // add_mod with both operands below modulus
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) add_mod = W'(s - {1'b0, m});
        else add_mod = s[W-1:0];
    endfunction

    logic [W-1:0] w_sel, w_red, w_sq, w_cbit, w_diff, w_gcd;
    assign w_sel = (r_phase == 2'd0) ? r_tort : r_hare;
    assign w_red = (w_sel >= r_mod) ? w_sel - r_mod : w_sel;
    assign w_sq = add_mod(r_acc, r_cred, r_mod);
    assign w_cbit = {{(W-1){1'b0}}, r_csh[W-1]};
    assign w_diff = (r_tort > r_hare) ? r_tort - r_hare : r_hare - r_tort;
    assign w_gcd = r_ga << r_twos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= LIMIT_RESET;
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= 1'b0;
            r_state  <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_limit <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mod   <= i_item.modulus_n;
                        r_sum   <= i_item.start_summand;
                        r_csh   <= i_item.start_summand;
                        r_tort  <= W'(2);
                        r_hare  <= W'(2);
                        r_steps <= '0;
                        r_cred  <= '0;
                        r_cnt   <= '0;
                    end
                end
                S_CRED: begin
                    r_cred <= add_mod(add_mod(r_cred, r_cred, r_mod), w_cbit, r_mod);
                    r_csh  <= r_csh << 1;
                    r_cnt  <= r_cnt + CW'(1);
                end
                S_CHECK: begin
                    if (r_mod < W'(2)) begin
                        r_result <= '{factor: '0, summand_used: '0, status: ST_INVALID};
                        r_rvalid <= 1'b1;
                    end else if (r_steps >= r_limit) begin
                        r_result <= '{factor: '0, summand_used: '0, status: ST_LIMIT};
                        r_rvalid <= 1'b1;
                    end else begin
                        r_steps <= r_steps + LIMIT_BITS'(1);
                        r_phase <= 2'd0;
                    end
                end
                S_MINIT: begin
                    r_acc  <= '0;
                    r_base <= w_red;
                    r_k    <= w_red;
                end
                S_MUL: begin
                    if (r_k != '0) begin
                        if (r_k[0]) r_acc <= add_mod(r_acc, r_base, r_mod);
                        r_base <= add_mod(r_base, r_base, r_mod);
                        r_k    <= r_k >> 1;
                    end
                end
                S_ADDC: begin
                    if (r_phase == 2'd0) r_tort <= w_sq;
                    else r_hare <= w_sq;
                    r_phase <= r_phase + 2'd1;
                end
                S_GINIT: begin
                    r_ga   <= w_diff;
                    r_gb   <= r_mod;
                    r_twos <= '0;
                end
                S_GTWO: begin
                    if (r_ga != '0 && !r_ga[0]) begin
                        if (!r_gb[0]) begin
                            r_ga   <= r_ga >> 1;
                            r_gb   <= r_gb >> 1;
                            r_twos <= r_twos + CW'(1);
                        end else begin
                            r_ga <= r_ga >> 1;
                        end
                    end
                end
                S_GLOOP: begin
                    if (r_gb != '0) begin
                        if (!r_gb[0]) r_gb <= r_gb >> 1;
                        else if (r_ga > r_gb) begin
                            r_ga <= r_gb;
                            r_gb <= r_ga - r_gb;
                        end else begin
                            r_gb <= r_gb - r_ga;
                        end
                    end else if (w_gcd != W'(1) && w_gcd != r_mod) begin
                        r_result <= '{factor: w_gcd, summand_used: r_sum, status: ST_FOUND};
                        r_rvalid <= 1'b1;
                    end
                end
                S_RESTART: begin
                    r_sum  <= r_sum + W'(1);
                    r_csh  <= r_sum + W'(1);
                    r_tort <= W'(2);
                    r_hare <= W'(2);
                    r_cred <= '0;
                    r_cnt  <= '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (start) n_state = S_CRED;
            S_CRED:    if (r_cnt == CW'(W - 1)) n_state = S_CHECK;
            S_CHECK:   n_state = (r_mod < W'(2) || r_steps >= r_limit) ? S_IDLE : S_MINIT;
            S_MINIT:   n_state = S_MUL;
            S_MUL:     if (r_k == '0) n_state = S_ADDC;
            S_ADDC:    n_state = (r_phase == 2'd2) ? S_GINIT : S_MINIT;
            S_GINIT:   n_state = S_GTWO;
            S_GTWO: begin
                if (r_ga == '0) n_state = S_RESTART;
                else if (r_ga[0]) n_state = S_GLOOP;
            end
            S_GLOOP: begin
                if (r_gb == '0) begin
                    if (w_gcd == W'(1)) n_state = S_CHECK;
                    else if (w_gcd == r_mod) n_state = S_RESTART;
                    else n_state = S_IDLE;
                end
            end
            S_RESTART: n_state = S_CRED;
            default:   n_state = S_IDLE;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_steps <= r_limit)
        else $error("step count beyond limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule
